// File: sv/lbbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbt_pkg: shared types and constants of the beat and bar tracker
// Item layouts, configuration view, the shared shift-add unit's control
// groups and the sequencer's state encoding.
// ----------------------------------------------------------------------------
package lbbt_pkg;

   localparam int CNT_W      = 5;   // beat, bar and limit counters
   localparam int TEMPO_W    = 9;
   localparam int ELAPSED_W  = 16;
   localparam int FRAC_W     = 16;
   localparam int ACTION_W   = 3;
   localparam int OPB_W      = 10;  // multiplier / dividend width of the unit
   localparam int ACC_W      = FRAC_W + OPB_W;  // product width
   localparam int ALU_STEPS  = OPB_W;
   localparam int STEP_W     = $clog2(ALU_STEPS);
   localparam int HALF_BEAT_MS = 60000;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int DEF_MAX_BEATS_PER_BAR = 16;
   localparam int DEF_MAX_LOOP_BARS     = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK    = 3'd0,
      ACT_START   = 3'd1,
      ACT_STOP    = 3'd2,
      ACT_RESET   = 3'd3,
      ACT_SET_POS = 3'd4
   } action_type;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

   typedef struct packed {
      logic [TEMPO_W-1:0] tempo_bpm;
      logic [CNT_W-1:0]   loop_bars;
      logic [CNT_W-1:0]   beats_per_bar;
   } cfg_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [FRAC_W-1:0]   position_frac;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] beat_number;
      logic [CNT_W-1:0] bar_number;
      logic             beat_phase;
      logic             is_running;
      logic             beat_advanced;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_MUL,
      ST_BEAT_DIV,
      ST_BAR_DIV,
      ST_POS_MUL1,
      ST_POS_MUL2,
      ST_POS_DIV,
      ST_DONE
   } state_type;

endpackage

// File: sv/lbbt_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbt_csr: configuration registers
// Tempo, loop length and bar length behind a simple APB-style port.
// ----------------------------------------------------------------------------
module lbbt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lbbt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lbbt_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lbbt_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output lbbt_pkg::cfg_type                  cfg
);

   localparam logic [1:0] REG_TEMPO = 2'd0;
   localparam logic [1:0] REG_BARS  = 2'd1;
   localparam logic [1:0] REG_BEATS = 2'd2;

   logic [lbbt_pkg::TEMPO_W-1:0] tempo_ff, tempo_in;
   logic [lbbt_pkg::CNT_W-1:0]   bars_ff, bars_in;
   logic [lbbt_pkg::CNT_W-1:0]   beats_ff, beats_in;
   logic                         wr_en;
   logic [1:0]                   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];

   always_comb begin
      tempo_in = tempo_ff;
      bars_in  = bars_ff;
      beats_in = beats_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TEMPO: tempo_in = pwdata[lbbt_pkg::TEMPO_W-1:0];
            REG_BARS:  bars_in  = pwdata[lbbt_pkg::CNT_W-1:0];
            REG_BEATS: beats_in = pwdata[lbbt_pkg::CNT_W-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_TEMPO: prdata = lbbt_pkg::CSR_DATA_W'(tempo_ff);
         REG_BARS:  prdata = lbbt_pkg::CSR_DATA_W'(bars_ff);
         REG_BEATS: prdata = lbbt_pkg::CSR_DATA_W'(beats_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff <= lbbt_pkg::TEMPO_W'(120);
         bars_ff  <= lbbt_pkg::CNT_W'(4);
         beats_ff <= lbbt_pkg::CNT_W'(4);
      end else begin
         tempo_ff <= tempo_in;
         bars_ff  <= bars_in;
         beats_ff <= beats_in;
      end
   end

   assign cfg.tempo_bpm     = tempo_ff;
   assign cfg.loop_bars     = bars_ff;
   assign cfg.beats_per_bar = beats_ff;

endmodule

// File: sv/lbbt_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbt_alu: shared shift-add multiplier and restoring divider
// One adder, one step per cycle. MUL: opa times opb. DIV: opb divided by
// opa, quotient in quo and remainder in acc.
// ----------------------------------------------------------------------------
module lbbt_alu (
   input  logic                           clock,
   input  logic                           reset,
   input  lbbt_pkg::alu_cmd_type          cmd,
   input  logic [lbbt_pkg::ACC_W-1:0]     opa,
   input  logic [lbbt_pkg::OPB_W-1:0]     opb,
   output lbbt_pkg::alu_sts_type          sts,
   output logic [lbbt_pkg::ACC_W-1:0]     acc,
   output logic [lbbt_pkg::OPB_W-1:0]     quo
);

   localparam int AW = lbbt_pkg::ACC_W;
   localparam int BW = lbbt_pkg::OPB_W;
   localparam logic [lbbt_pkg::STEP_W-1:0] LAST_STEP =
      lbbt_pkg::STEP_W'(lbbt_pkg::ALU_STEPS - 1);

   lbbt_pkg::alu_op_type op_ff, op_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [lbbt_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic [AW-1:0]        mc_ff, mc_in;   // multiplicand, or divisor
   logic [BW-1:0]        mp_ff, mp_in;   // multiplier, or dividend / quotient

   logic [AW-1:0]        partial;
   logic [AW-1:0]        add_b;
   logic [AW:0]          sum;
   logic                 is_div;

   assign is_div  = (op_ff == lbbt_pkg::ALU_DIV);
   assign partial = is_div ? {acc_ff[AW-2:0], mp_ff[BW-1]} : acc_ff;
   assign add_b   = is_div ? ~mc_ff : (mp_ff[0] ? mc_ff : '0);
   // carry out on a divide step means the trial subtraction did not borrow
   assign sum     = {1'b0, partial} + {1'b0, add_b} + (AW+1)'(is_div);

   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         mc_in   = opa;
         mp_in   = opb;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (is_div) begin
            acc_in = sum[AW] ? sum[AW-1:0] : partial;
            mp_in  = {mp_ff[BW-2:0], sum[AW]};
         end else begin
            acc_in = sum[AW-1:0];
            mc_in  = {mc_ff[AW-2:0], 1'b0};
            mp_in  = {1'b0, mp_ff[BW-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= lbbt_pkg::ALU_MUL;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         op_ff   <= op_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign acc      = acc_ff;
   assign quo      = mp_ff;

endmodule

// File: sv/lbbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbt_ctrl: sequencer and tracker state
// Decodes one item, drives the shared unit step by step and updates the
// elapsed count, phase, beat, bar and pending flags.
// ----------------------------------------------------------------------------
module lbbt_ctrl #(
   parameter int MAX_BEATS_PER_BAR = lbbt_pkg::DEF_MAX_BEATS_PER_BAR,
   parameter int MAX_LOOP_BARS     = lbbt_pkg::DEF_MAX_LOOP_BARS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lbbt_pkg::cfg_type              cfg,
   input  logic                           req_valid,
   input  lbbt_pkg::req_type              req_data,
   output logic                           req_stall,
   input  logic                           out_free,
   output logic                           res_load,
   output lbbt_pkg::rsp_type              res_data,
   output lbbt_pkg::alu_cmd_type          alu_cmd,
   output logic [lbbt_pkg::ACC_W-1:0]     alu_opa,
   output logic [lbbt_pkg::OPB_W-1:0]     alu_opb,
   input  lbbt_pkg::alu_sts_type          alu_sts,
   input  logic [lbbt_pkg::ACC_W-1:0]     alu_acc,
   input  logic [lbbt_pkg::OPB_W-1:0]     alu_quo
);

   localparam int CW = lbbt_pkg::CNT_W;
   localparam int CNT_MAX = (1 << CW) - 1;
   localparam logic [CW-1:0] BEATS_TOP =
      (MAX_BEATS_PER_BAR > CNT_MAX) ? CW'(CNT_MAX) : CW'(MAX_BEATS_PER_BAR);
   localparam logic [CW-1:0] BARS_TOP =
      (MAX_LOOP_BARS > CNT_MAX) ? CW'(CNT_MAX) : CW'(MAX_LOOP_BARS);
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [lbbt_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;

   lbbt_pkg::state_type state_ff, state_in;
   logic [lbbt_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [CW-1:0]  beat_ff, beat_in;
   logic [CW-1:0]  bar_ff, bar_in;
   logic           phase_ff, phase_in;
   logic           pending_ff, pending_in;
   logic           running_ff, running_in;
   logic           advanced_ff, advanced_in;
   logic [lbbt_pkg::FRAC_W-1:0] frac_ff, frac_in;

   logic [CW-1:0]  beats_use;
   logic [CW-1:0]  bars_use;
   logic [lbbt_pkg::ELAPSED_W-1:0] elapsed_sat;
   logic           half_pass;
   logic           beat_step;
   logic [CW-1:0]  rem_plus1;
   logic [CW-1:0]  quo_plus1;

   assign beats_use = (cfg.beats_per_bar == '0) ? ONE :
                      (cfg.beats_per_bar > BEATS_TOP) ? BEATS_TOP : cfg.beats_per_bar;
   assign bars_use  = (cfg.loop_bars == '0) ? ONE :
                      (cfg.loop_bars > BARS_TOP) ? BARS_TOP : cfg.loop_bars;

   assign elapsed_sat = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign half_pass   = (alu_acc >= lbbt_pkg::ACC_W'(lbbt_pkg::HALF_BEAT_MS));
   // phase toggles to the beat half while counting
   assign beat_step   = half_pass && running_ff && !phase_ff;
   assign rem_plus1   = alu_acc[CW-1:0] + 1'b1;
   assign quo_plus1   = alu_quo[CW-1:0] + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbbt_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (lbbt_pkg::action_type'(req_data.action))
                  lbbt_pkg::ACT_TICK:    state_in = lbbt_pkg::ST_TICK_MUL;
                  lbbt_pkg::ACT_SET_POS: state_in = lbbt_pkg::ST_POS_MUL1;
                  default:               state_in = lbbt_pkg::ST_DONE;
               endcase
            end
         end
         lbbt_pkg::ST_TICK_MUL: begin
            if (alu_sts.done) begin
               state_in = beat_step ? lbbt_pkg::ST_BEAT_DIV : lbbt_pkg::ST_DONE;
            end
         end
         lbbt_pkg::ST_BEAT_DIV: begin
            if (alu_sts.done) begin
               state_in = pending_ff ? lbbt_pkg::ST_BAR_DIV : lbbt_pkg::ST_DONE;
            end
         end
         lbbt_pkg::ST_BAR_DIV: begin
            if (alu_sts.done) state_in = lbbt_pkg::ST_DONE;
         end
         lbbt_pkg::ST_POS_MUL1: begin
            if (alu_sts.done) state_in = lbbt_pkg::ST_POS_MUL2;
         end
         lbbt_pkg::ST_POS_MUL2: begin
            if (alu_sts.done) state_in = lbbt_pkg::ST_POS_DIV;
         end
         lbbt_pkg::ST_POS_DIV: begin
            if (alu_sts.done) state_in = lbbt_pkg::ST_DONE;
         end
         lbbt_pkg::ST_DONE: begin
            if (out_free) state_in = lbbt_pkg::ST_IDLE;
         end
         default: state_in = lbbt_pkg::ST_IDLE;
      endcase
   end

   // outputs: unit commands and handshake
   always_comb begin
      alu_cmd.start = 1'b0;
      alu_cmd.op    = lbbt_pkg::ALU_MUL;
      alu_opa       = '0;
      alu_opb       = '0;
      req_stall     = 1'b1;
      res_load      = 1'b0;
      unique case (state_ff)
         lbbt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (lbbt_pkg::action_type'(req_data.action))
                  lbbt_pkg::ACT_TICK: begin
                     alu_cmd.start = 1'b1;
                     alu_opa = lbbt_pkg::ACC_W'(elapsed_sat);
                     alu_opb = lbbt_pkg::OPB_W'({cfg.tempo_bpm, 1'b0});
                  end
                  lbbt_pkg::ACT_SET_POS: begin
                     alu_cmd.start = 1'b1;
                     alu_opa = lbbt_pkg::ACC_W'(beats_use);
                     alu_opb = lbbt_pkg::OPB_W'(bars_use);
                  end
                  default: ;
               endcase
            end
         end
         lbbt_pkg::ST_TICK_MUL: begin
            if (alu_sts.done && beat_step) begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = lbbt_pkg::ALU_DIV;
               alu_opa = lbbt_pkg::ACC_W'(beats_use);
               alu_opb = lbbt_pkg::OPB_W'(beat_ff);
            end
         end
         lbbt_pkg::ST_BEAT_DIV: begin
            if (alu_sts.done && pending_ff) begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = lbbt_pkg::ALU_DIV;
               alu_opa = lbbt_pkg::ACC_W'(bars_use);
               alu_opb = lbbt_pkg::OPB_W'(bar_ff);
            end
         end
         lbbt_pkg::ST_POS_MUL1: begin
            if (alu_sts.done) begin
               alu_cmd.start = 1'b1;
               alu_opa = lbbt_pkg::ACC_W'(frac_ff);
               alu_opb = alu_acc[lbbt_pkg::OPB_W-1:0];
            end
         end
         lbbt_pkg::ST_POS_MUL2: begin
            if (alu_sts.done) begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = lbbt_pkg::ALU_DIV;
               alu_opa = lbbt_pkg::ACC_W'(beats_use);
               alu_opb = alu_acc[lbbt_pkg::ACC_W-1 -: lbbt_pkg::OPB_W];
            end
         end
         lbbt_pkg::ST_DONE: res_load = out_free;
         default: ;
      endcase
   end

   // tracker state
   always_comb begin
      elapsed_in  = elapsed_ff;
      beat_in     = beat_ff;
      bar_in      = bar_ff;
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      running_in  = running_ff;
      advanced_in = advanced_ff;
      frac_in     = frac_ff;
      unique case (state_ff)
         lbbt_pkg::ST_IDLE: begin
            if (req_valid) begin
               advanced_in = 1'b0;
               unique case (lbbt_pkg::action_type'(req_data.action))
                  lbbt_pkg::ACT_TICK: elapsed_in = elapsed_sat;
                  lbbt_pkg::ACT_START: begin
                     running_in = 1'b1;
                     elapsed_in = '0;
                  end
                  lbbt_pkg::ACT_STOP: running_in = 1'b0;
                  lbbt_pkg::ACT_RESET: begin
                     beat_in    = ONE;
                     bar_in     = ONE;
                     pending_in = 1'b0;
                     elapsed_in = '0;
                  end
                  lbbt_pkg::ACT_SET_POS: begin
                     running_in = 1'b0;
                     frac_in    = req_data.position_frac;
                  end
                  default: ;
               endcase
            end
         end
         lbbt_pkg::ST_TICK_MUL: begin
            if (alu_sts.done && half_pass) begin
               elapsed_in  = '0;
               phase_in    = !phase_ff;
               advanced_in = beat_step;
            end
         end
         lbbt_pkg::ST_BEAT_DIV: begin
            if (alu_sts.done) begin
               beat_in    = rem_plus1;
               pending_in = (rem_plus1 == beats_use);
            end
         end
         lbbt_pkg::ST_BAR_DIV: begin
            if (alu_sts.done) bar_in = rem_plus1;
         end
         lbbt_pkg::ST_POS_DIV: begin
            if (alu_sts.done) begin
               bar_in  = quo_plus1;
               beat_in = rem_plus1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lbbt_pkg::ST_IDLE;
         elapsed_ff  <= '0;
         beat_ff     <= ONE;
         bar_ff      <= ONE;
         phase_ff    <= 1'b1;
         pending_ff  <= 1'b0;
         running_ff  <= 1'b0;
         advanced_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         elapsed_ff  <= elapsed_in;
         beat_ff     <= beat_in;
         bar_ff      <= bar_in;
         phase_ff    <= phase_in;
         pending_ff  <= pending_in;
         running_ff  <= running_in;
         advanced_ff <= advanced_in;
      end
      frac_ff <= frac_in;
   end

   assign res_data.beat_number   = beat_ff;
   assign res_data.bar_number    = bar_ff;
   assign res_data.beat_phase    = phase_ff;
   assign res_data.is_running    = running_ff;
   assign res_data.beat_advanced = advanced_ff;

endmodule

// File: sv/looper_beat_bar_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looper_beat_bar_tracker: beat and bar counter for a loop recorder
// Counts half-beats from millisecond tick items and reports beat, bar and
// phase after every item.
// ----------------------------------------------------------------------------
// One item is taken at a time and every item gives exactly one result. The
// time per item is set by one shared shift-add / shift-subtract unit: each
// multiply or divide runs 10 steps, and the sequencer reads each result and
// starts the next operation when the unit reports done. After the last
// operation the sequencer passes through a done state, which hands the result
// to the output register, and then back to idle. A plain tick runs one
// multiply, a tick that advances the beat adds one divide, and one that also
// advances the bar a second divide; a set-position item runs two multiplies
// and one divide. Start, stop, reset and unknown action codes use the unit not
// at all. The done state waits as long as a result still held in the output
// register stays stalled on rsp_. The output register lets the next item
// start while a result is still stalled on rsp_.
// Configuration writes belong to idle periods only.
// ----------------------------------------------------------------------------
module looper_beat_bar_tracker #(
   parameter int MAX_BEATS_PER_BAR = lbbt_pkg::DEF_MAX_BEATS_PER_BAR,
   parameter int MAX_LOOP_BARS     = lbbt_pkg::DEF_MAX_LOOP_BARS
) (
   input  logic                             clock,
   input  logic                             reset,
   // item input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lbbt_pkg::req_type                req_data,
   // result output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lbbt_pkg::rsp_type                rsp_data,
   // configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lbbt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lbbt_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lbbt_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   lbbt_pkg::cfg_type      cfg;
   lbbt_pkg::alu_cmd_type  alu_cmd;
   lbbt_pkg::alu_sts_type  alu_sts;
   logic [lbbt_pkg::ACC_W-1:0] alu_opa;
   logic [lbbt_pkg::OPB_W-1:0] alu_opb;
   logic [lbbt_pkg::ACC_W-1:0] alu_acc;
   logic [lbbt_pkg::OPB_W-1:0] alu_quo;

   logic              res_load;
   lbbt_pkg::rsp_type res_data;
   logic              out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   lbbt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   lbbt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lbbt_ctrl #(
      .MAX_BEATS_PER_BAR (MAX_BEATS_PER_BAR),
      .MAX_LOOP_BARS     (MAX_LOOP_BARS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_free  (out_free),
      .res_load  (res_load),
      .res_data  (res_data),
      .alu_cmd   (alu_cmd),
      .alu_opa   (alu_opa),
      .alu_opb   (alu_opb),
      .alu_sts   (alu_sts),
      .alu_acc   (alu_acc),
      .alu_quo   (alu_quo)
   );

   lbbt_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (alu_opa),
      .opb   (alu_opb),
      .sts   (alu_sts),
      .acc   (alu_acc),
      .quo   (alu_quo)
   );

   // Output register: free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_valid_ff && rsp_stall) begin
         // hold the stalled item
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted item keeps the input closed on the next cycle.
   a_accept_closes_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after an accepted item");

   // The shared unit only runs while an item is in progress.
   a_unit_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      alu_sts.busy |-> req_stall)
      else $error("input open while the shared unit is busy");

   // Beat and bar count from one.
   a_counts_from_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.beat_number != '0 && rsp_data.bar_number != '0))
      else $error("beat or bar reported as zero");

   // A beat advances only on the beat half while running.
   a_advance_on_beat_half: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.beat_advanced) |->
         (rsp_data.beat_phase && rsp_data.is_running))
      else $error("beat advanced off the beat half or while stopped");

endmodule

// File: tb/sv/looper_beat_bar_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looper_beat_bar_tracker_tb: self-checking bench for the beat and bar tracker
// Sends a directed table of items, then a run of ticks at zero tempo that lets
// the elapsed count grow, then phases of random items under several register
// settings. Every result is checked field by field against an in-bench
// predictor of the tracker, with random idling on both channels.
// ----------------------------------------------------------------------------
module looper_beat_bar_tracker_tb;

   // Limits as instantiated (the block runs with its default parameters)
   localparam int unsigned MAX_BEATS = lbbt_pkg::DEF_MAX_BEATS_PER_BAR;
   localparam int unsigned MAX_BARS  = lbbt_pkg::DEF_MAX_LOOP_BARS;

   // Action codes the block must ignore
   localparam logic [lbbt_pkg::ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [lbbt_pkg::ACTION_W-1:0] ACT_SPARE_MID = 3'd6;
   localparam logic [lbbt_pkg::ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;

   localparam int unsigned DIRECTED_ROWS  = 26;
   localparam int unsigned PHASES         = 8;
   // Ticks at zero tempo; enough that the held count passes the half-beat at
   // once when a fast tempo follows
   localparam int unsigned HOLD_TICKS     = 120;
   // Longest items run three unit operations; leave margin after the drain
   localparam int unsigned SETTLE_CYCLES  = 60;
   localparam int unsigned PRINT_LIMIT    = 50;
   // Slowest correct run: ~1.7k items of the longest kind with the longest
   // gaps and stalls, plus register traffic, about 3 ms in all
   localparam int unsigned RUN_LIMIT_NS   = 50_000_000;

   typedef enum logic [1:0] {
      REG_TEMPO_BPM,
      REG_LOOP_BARS,
      REG_BEATS_PER_BAR
   } csr_reg_type;

   localparam logic [lbbt_pkg::CSR_DATA_W-1:0] CSR_RESET_VALUE [3] =
      '{32'd120, 32'd4, 32'd4};

   // One row of the directed table: a register write or an item, with the
   // result typed in where it is obvious
   typedef struct packed {
      logic                            is_write;
      csr_reg_type                     reg_sel;
      logic [lbbt_pkg::CSR_DATA_W-1:0] value;
      lbbt_pkg::req_type               item;
      logic                            typed;
      lbbt_pkg::rsp_type               want;
   } plan_row_type;

   // Register setting and length of one random phase
   typedef struct packed {
      logic [lbbt_pkg::TEMPO_W-1:0] tempo;
      logic [lbbt_pkg::CNT_W-1:0]   bars;
      logic [lbbt_pkg::CNT_W-1:0]   beats;
      logic [15:0]                  count;
      logic                         idle;
   } setting_type;

   // Fast tempos so that beats and bars turn over inside a phase; extremes,
   // zero and out-of-range limits among them
   localparam setting_type PHASE_PLAN [PHASES] = '{
      '{9'd511, 5'd1,  5'd1,  16'd230, 1'b1},
      '{9'd300, 5'd16, 5'd16, 16'd230, 1'b0},
      '{9'd511, 5'd2,  5'd3,  16'd230, 1'b1},
      '{9'd1,   5'd4,  5'd4,  16'd60,  1'b1},
      '{9'd0,   5'd0,  5'd17, 16'd60,  1'b0},
      '{9'd480, 5'd17, 5'd2,  16'd230, 1'b1},
      '{9'd511, 5'd5,  5'd31, 16'd230, 1'b1},
      '{9'd420, 5'd3,  5'd1,  16'd230, 1'b0}
   };

   // ------------------------------------------------------------------
   // Block ports, all driven to known values from time zero
   // ------------------------------------------------------------------
   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   lbbt_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   lbbt_pkg::rsp_type               rsp_data;
   logic                            psel      = 1'b0;
   logic                            penable   = 1'b0;
   logic                            pwrite    = 1'b0;
   logic [lbbt_pkg::CSR_ADDR_W-1:0] paddr     = '0;
   logic [lbbt_pkg::CSR_DATA_W-1:0] pwdata    = '0;
   logic [lbbt_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   // ------------------------------------------------------------------
   // Predictor copy of the tracker state and its registers
   // ------------------------------------------------------------------
   logic [lbbt_pkg::ELAPSED_W-1:0] ms_count   = '0;
   logic [lbbt_pkg::CNT_W-1:0]     beat_cnt   = 5'd1;
   logic [lbbt_pkg::CNT_W-1:0]     bar_cnt    = 5'd1;
   logic                           half_phase = 1'b1;
   logic                           bar_due    = 1'b0;
   logic                           counting   = 1'b0;
   logic [lbbt_pkg::TEMPO_W-1:0]   cfg_tempo  = 9'd120;
   logic [lbbt_pkg::CNT_W-1:0]     cfg_bars   = 5'd4;
   logic [lbbt_pkg::CNT_W-1:0]     cfg_beats  = 5'd4;

   // Beat and bar reports still owed by the block, oldest first
   lbbt_pkg::rsp_type due_positions [$];

   logic        idle_on         = 1'b1;
   int unsigned stall_left      = 0;
   int unsigned error_count     = 0;
   int unsigned items_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned beat_steps      = 0;
   int unsigned bar_steps       = 0;
   int unsigned csr_writes      = 0;

   plan_row_type directed_plan [DIRECTED_ROWS];

   looper_beat_bar_tracker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      end
      error_count++;
   endtask

   // Mostly short idles, now and then a long one
   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Limit register as the block uses it: zero counts as one, the top is held
   function automatic int unsigned clamp_limit(logic [lbbt_pkg::CNT_W-1:0] v,
                                               int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return 32'(v);
   endfunction

   // Advance the predicted tracker by one item and return the report it owes
   function automatic lbbt_pkg::rsp_type track_item(lbbt_pkg::req_type item);
      lbbt_pkg::rsp_type shown;
      int unsigned       beats;
      int unsigned       bars;
      int unsigned       total;
      logic              stepped;
      beats   = clamp_limit(cfg_beats, MAX_BEATS);
      bars    = clamp_limit(cfg_bars, MAX_BARS);
      stepped = 1'b0;
      case (item.action)
         lbbt_pkg::ACT_TICK: begin
            // Elapsed count holds at its top instead of wrapping
            if (ms_count != '1) ms_count = ms_count + 1'b1;
            if (32'(ms_count) * 32'(cfg_tempo) * 32'd2 >= 32'(lbbt_pkg::HALF_BEAT_MS)) begin
               ms_count   = '0;
               half_phase = ~half_phase;
               // Only the rising half of a beat moves the counters
               if (counting && half_phase) begin
                  stepped  = 1'b1;
                  beat_cnt = lbbt_pkg::CNT_W'(32'(beat_cnt) % beats + 1);
                  beat_steps++;
                  // The bar turns on the beat after the last beat of a bar
                  if (bar_due) begin
                     bar_cnt = lbbt_pkg::CNT_W'(32'(bar_cnt) % bars + 1);
                     bar_due = 1'b0;
                     bar_steps++;
                  end
                  if (32'(beat_cnt) == beats) bar_due = 1'b1;
               end
            end
         end
         lbbt_pkg::ACT_START: begin
            counting = 1'b1;
            ms_count = '0;
         end
         lbbt_pkg::ACT_STOP: begin
            counting = 1'b0;
         end
         lbbt_pkg::ACT_RESET: begin
            beat_cnt = 5'd1;
            bar_cnt  = 5'd1;
            bar_due  = 1'b0;
            ms_count = '0;
         end
         lbbt_pkg::ACT_SET_POS: begin
            // Scale the fraction to whole beats of the loop, then split
            total    = (32'(item.position_frac) * beats * bars) >> lbbt_pkg::FRAC_W;
            counting = 1'b0;
            bar_cnt  = lbbt_pkg::CNT_W'(total / beats + 1);
            beat_cnt = lbbt_pkg::CNT_W'(total % beats + 1);
         end
         default: ;
      endcase
      shown.beat_number   = beat_cnt;
      shown.bar_number    = bar_cnt;
      shown.beat_phase    = half_phase;
      shown.is_running    = counting;
      shown.beat_advanced = stepped;
      return shown;
   endfunction

   // Mostly ticks; start often while stopped so counting keeps going
   function automatic lbbt_pkg::req_type random_item();
      lbbt_pkg::req_type it;
      int unsigned       r;
      r = $urandom_range(0, 999);
      it.position_frac = 16'($urandom);
      if (!counting && r < 80) it.action = lbbt_pkg::ACT_START;
      else if (r < 930) it.action = lbbt_pkg::ACT_TICK;
      else if (r < 945) it.action = lbbt_pkg::ACT_START;
      else if (r < 955) it.action = lbbt_pkg::ACT_STOP;
      else if (r < 965) it.action = lbbt_pkg::ACT_RESET;
      else if (r < 985) it.action = lbbt_pkg::ACT_SET_POS;
      else it.action = lbbt_pkg::ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      return it;
   endfunction

   function automatic plan_row_type item_row(logic [lbbt_pkg::ACTION_W-1:0] act,
                                             logic [lbbt_pkg::FRAC_W-1:0] frac);
      plan_row_type row;
      row      = '0;
      row.item = '{act, frac};
      return row;
   endfunction

   function automatic plan_row_type typed_row(logic [lbbt_pkg::ACTION_W-1:0] act,
                                              logic [lbbt_pkg::FRAC_W-1:0] frac,
                                              logic [lbbt_pkg::CNT_W-1:0] beat,
                                              logic [lbbt_pkg::CNT_W-1:0] bar,
                                              logic ph, logic run);
      plan_row_type row;
      row       = item_row(act, frac);
      row.typed = 1'b1;
      row.want  = '{beat, bar, ph, run, 1'b0};
      return row;
   endfunction

   function automatic plan_row_type write_row(csr_reg_type r,
                                              logic [lbbt_pkg::CSR_DATA_W-1:0] v);
      plan_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.reg_sel  = r;
      row.value    = v;
      return row;
   endfunction

   // ------------------------------------------------------------------
   // Item sender: random gap, hold the item until taken, then predict
   // ------------------------------------------------------------------
   task automatic send_item(lbbt_pkg::req_type item, logic typed, lbbt_pkg::rsp_type want);
      int unsigned       gap;
      lbbt_pkg::rsp_type predicted;
      gap = (idle_on && $urandom_range(0, 99) < 30) ? pick_idle() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted = track_item(item);
      due_positions.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Drop valid and hold until every owed result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (due_positions.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // One register access: setup cycle, then access cycle until pready
   task automatic csr_access(csr_reg_type r, logic wr,
                             logic [lbbt_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [lbbt_pkg::CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= lbbt_pkg::CSR_ADDR_W'(4 * int'(r));
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write a register, mirror it into the predictor and read it back
   task automatic csr_write(csr_reg_type r, logic [lbbt_pkg::CSR_DATA_W-1:0] value);
      logic [lbbt_pkg::CSR_DATA_W-1:0] rd;
      logic [lbbt_pkg::CSR_DATA_W-1:0] kept;
      kept = value & ((r == REG_TEMPO_BPM) ? (32'd1 << lbbt_pkg::TEMPO_W) - 1 :
                                             (32'd1 << lbbt_pkg::CNT_W) - 1);
      csr_access(r, 1'b1, value, rd);
      case (r)
         REG_TEMPO_BPM: cfg_tempo = kept[lbbt_pkg::TEMPO_W-1:0];
         REG_LOOP_BARS: cfg_bars  = kept[lbbt_pkg::CNT_W-1:0];
         default:       cfg_beats = kept[lbbt_pkg::CNT_W-1:0];
      endcase
      csr_access(r, 1'b0, '0, rd);
      if (rd != kept) report_mismatch("register readback", rd, kept);
      csr_writes++;
   endtask

   // ------------------------------------------------------------------
   // Result checker and receiver stall pattern
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      lbbt_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_positions.size() == 0) begin
            report_mismatch("result with nothing owed", 32'(rsp_data), 0);
         end else begin
            want = due_positions.pop_front();
            if (rsp_data.beat_number != want.beat_number)
               report_mismatch("beat_number", 32'(rsp_data.beat_number),
                               32'(want.beat_number));
            if (rsp_data.bar_number != want.bar_number)
               report_mismatch("bar_number", 32'(rsp_data.bar_number),
                               32'(want.bar_number));
            if (rsp_data.beat_phase != want.beat_phase)
               report_mismatch("beat_phase", 32'(rsp_data.beat_phase),
                               32'(want.beat_phase));
            if (rsp_data.is_running != want.is_running)
               report_mismatch("is_running", 32'(rsp_data.is_running),
                               32'(want.is_running));
            if (rsp_data.beat_advanced != want.beat_advanced)
               report_mismatch("beat_advanced", 32'(rsp_data.beat_advanced),
                               32'(want.beat_advanced));
            results_checked++;
         end
      end
      // Stall in bursts of random length, with free runs in between
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 99) < 20) stall_left = pick_idle();
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [lbbt_pkg::CSR_DATA_W-1:0] rd;
      logic [lbbt_pkg::FRAC_W-1:0]     end_frac;

      // Directed table; typed results hold at default registers after reset
      directed_plan = '{
         typed_row(lbbt_pkg::ACT_TICK,    16'h0000, 5'd1, 5'd1, 1'b1, 1'b0),
         typed_row(ACT_SPARE_LO,          16'hFFFF, 5'd1, 5'd1, 1'b1, 1'b0),
         typed_row(ACT_SPARE_MID,         16'h0000, 5'd1, 5'd1, 1'b1, 1'b0),
         typed_row(ACT_SPARE_HI,          16'hA5A5, 5'd1, 5'd1, 1'b1, 1'b0),
         typed_row(lbbt_pkg::ACT_START,   16'h0000, 5'd1, 5'd1, 1'b1, 1'b1),
         typed_row(lbbt_pkg::ACT_STOP,    16'h0000, 5'd1, 5'd1, 1'b1, 1'b0),
         typed_row(lbbt_pkg::ACT_SET_POS, 16'h0000, 5'd1, 5'd1, 1'b1, 1'b0),
         typed_row(lbbt_pkg::ACT_SET_POS, 16'hFFFF, 5'd4, 5'd4, 1'b1, 1'b0),
         typed_row(lbbt_pkg::ACT_RESET,   16'hFFFF, 5'd1, 5'd1, 1'b1, 1'b0),
         item_row(lbbt_pkg::ACT_SET_POS,  16'h8000),
         item_row(lbbt_pkg::ACT_START,    16'h5A5A),
         item_row(lbbt_pkg::ACT_TICK,     16'hFFFF),
         typed_row(lbbt_pkg::ACT_RESET,   16'h0000, 5'd1, 5'd1, 1'b1, 1'b1),
         // Out-of-range limits: zero beats with too many bars, then the reverse
         write_row(REG_BEATS_PER_BAR, 32'd0),
         write_row(REG_LOOP_BARS,     32'd31),
         item_row(lbbt_pkg::ACT_SET_POS,  16'hFFFF),
         write_row(REG_BEATS_PER_BAR, 32'd31),
         write_row(REG_LOOP_BARS,     32'd0),
         item_row(lbbt_pkg::ACT_SET_POS,  16'hFFFF),
         // Zero tempo: the phase must hold
         write_row(REG_TEMPO_BPM,     32'd0),
         item_row(lbbt_pkg::ACT_START,    16'h0000),
         item_row(lbbt_pkg::ACT_TICK,     16'h0000),
         write_row(REG_TEMPO_BPM,     32'd511),
         write_row(REG_BEATS_PER_BAR, 32'd16),
         write_row(REG_LOOP_BARS,     32'd16),
         item_row(lbbt_pkg::ACT_SET_POS,  16'h1234)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Registers come out of reset at their defaults
      for (int i = 0; i < 3; i++) begin
         csr_access(csr_reg_type'(i), 1'b0, '0, rd);
         if (rd != CSR_RESET_VALUE[i])
            report_mismatch("register reset value", rd, CSR_RESET_VALUE[i]);
      end

      // Walk the directed table; drain before every register write
      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write) begin
            wait_drain();
            csr_write(directed_plan[i].reg_sel, directed_plan[i].value);
         end else begin
            send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      // Let the elapsed count grow at zero tempo, back to back, then raise the
      // tempo: the held count crosses the half-beat on the very next tick
      wait_drain();
      idle_on = 1'b0;
      csr_write(REG_TEMPO_BPM, 32'd0);
      repeat (HOLD_TICKS) send_item('{lbbt_pkg::ACT_TICK, 16'($urandom)}, 1'b0, '0);
      wait_drain();
      csr_write(REG_TEMPO_BPM, 32'd511);
      send_item('{lbbt_pkg::ACT_TICK, 16'h0000}, 1'b0, '0);

      // Random phases: start, a stream of mostly ticks, then a set position
      // that leaves the counters high for the next, possibly lower, limits
      for (int p = 0; p < PHASES; p++) begin
         wait_drain();
         idle_on = PHASE_PLAN[p].idle;
         csr_write(REG_TEMPO_BPM,     32'(PHASE_PLAN[p].tempo));
         csr_write(REG_LOOP_BARS,     32'(PHASE_PLAN[p].bars));
         csr_write(REG_BEATS_PER_BAR, 32'(PHASE_PLAN[p].beats));
         send_item('{lbbt_pkg::ACT_START, 16'($urandom)}, 1'b0, '0);
         for (int i = 1; i < PHASE_PLAN[p].count - 1; i++) begin
            // Now and then hold the sender until the block is empty
            if ($urandom_range(0, 99) == 0) wait_drain();
            send_item(random_item(), 1'b0, '0);
         end
         end_frac = (p % 2 == 0) ? 16'($urandom) : 16'hFFFF;
         send_item('{lbbt_pkg::ACT_SET_POS, end_frac}, 1'b0, '0);
      end

      // Drain, then give any stray result time to show up
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items and checked %0d results; %0d beat and %0d bar advances seen",
               items_sent, results_checked, beat_steps, bar_steps);
      $display("Made %0d register writes over %0d random settings and a %0d tick zero-tempo run",
               csr_writes, PHASES, HOLD_TICKS);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout after %0d ns", RUN_LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
